// File: rtl/euler_flux_2d_defines.svh
// Assertion macros used by the flux block.
`ifndef EULER_FLUX_2D_DEFINES_SVH
`define EULER_FLUX_2D_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define EF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, checked out of reset.
`define EF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: rtl/ef2d_pkg.sv
// Types and constants of the 2D Euler flux block.
package ef2d_pkg;

  // Default fraction bits of the Q formats
  localparam int FracBitsDef = 16;
  // Quotient bits kept by the momentum dividers; larger quotients saturate
  localparam int QM = 34;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic        [30:0] density;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] energy;
    logic signed [31:0] pressure;
    logic               flux_dir;
  } in_t;

  typedef struct packed {
    logic signed [31:0] mass_flux;
    logic signed [31:0] mom_x_flux;
    logic signed [31:0] mom_y_flux;
    logic signed [31:0] energy_flux;
    logic        [1:0]  status;
  } out_t;

endpackage

// File: rtl/euler_flux_2d.sv
// Pipelined 2D Euler flux of one cell along x or y.
// Registers in order: stage 1, stage 2, the divider stages, post stage 1, output.
// Throughput: one item per cycle; the restoring dividers take one quotient
// bit per stage over 32 + FRAC_BITS stages, which sets the depth.
// The whole pipeline halts while a result waits at the output register.
// Reset clears all valid bits asynchronously; the block is ready at once.
`include "euler_flux_2d_defines.svh"

module euler_flux_2d #(
  parameter int FRAC_BITS = ef2d_pkg::FracBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ef2d_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ef2d_pkg::out_t  out_data_o
);

  localparam int QM    = ef2d_pkg::QM;
  localparam int NSTEP = 32 + FRAC_BITS;     // velocity quotient bits
  localparam int DW    = 31 + NSTEP;         // width of shifted divisor
  localparam int HW    = NSTEP - 32;         // upper velocity slice
  localparam int SW    = NSTEP + 33;         // energy product width

  typedef struct packed {
    logic signed [63:0] pmx;
    logic signed [63:0] pmy;
    logic signed [31:0] md;
    logic signed [32:0] ep;
    logic signed [31:0] pr;
    logic               dir;
    logic        [30:0] rho;
  } s1_t;

  typedef struct packed {
    logic [63:0]        rm_x;
    logic [63:0]        rm_y;
    logic [63:0]        rm_v;
    logic [QM-1:0]      qx;
    logic [QM-1:0]      qy;
    logic [NSTEP-1:0]   qv;
    logic               sx;
    logic               sy;
    logic               neg_e;
    logic               bigx;
    logic               bigy;
    logic [32:0]        ue;
    logic signed [31:0] pr;
    logic               dir;
    logic signed [31:0] md;
    logic [30:0]        rho;
  } div_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               satm;
    logic [64:0]        mlo;
    logic [HW+32:0]     mhi;
    logic               neg_e;
    logic signed [31:0] md;
    logic               zero;
  } p1_t;

  logic             en;
  logic             v1_q;
  s1_t              s1_q;
  logic [NSTEP:0]   vd_q;
  div_t             dv_q [NSTEP+1];
  logic             vp1_q;
  p1_t              p1_q;
  logic             out_valid_q;
  ef2d_pkg::out_t   out_q;

  // Whole pipeline moves unless a result is held at the output
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      vd_q        <= '0;
      vp1_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      vd_q        <= {vd_q[NSTEP-1:0], v1_q};
      vp1_q       <= vd_q[NSTEP];
      out_valid_q <= vp1_q;
    end
  end

  // Stage 1: momentum products and energy plus pressure
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.md  <= in_data_i.flux_dir ? in_data_i.mom_y : in_data_i.mom_x;
      s1_q.pmx <= in_data_i.mom_x *
                  (in_data_i.flux_dir ? in_data_i.mom_y : in_data_i.mom_x);
      s1_q.pmy <= in_data_i.mom_y *
                  (in_data_i.flux_dir ? in_data_i.mom_y : in_data_i.mom_x);
      s1_q.ep  <= 33'(in_data_i.energy) + 33'(in_data_i.pressure);
      s1_q.pr  <= in_data_i.pressure;
      s1_q.dir <= in_data_i.flux_dir;
      s1_q.rho <= in_data_i.density;
    end
  end

  // Stage 2: magnitudes, signs and the large-quotient flags
  div_t s2_d;
  always_comb begin
    s2_d       = '0;
    s2_d.rm_x  = s1_q.pmx[63] ? 64'(-s1_q.pmx) : 64'(s1_q.pmx);
    s2_d.rm_y  = s1_q.pmy[63] ? 64'(-s1_q.pmy) : 64'(s1_q.pmy);
    // magnitude of the most negative momentum is 2^31, kept unsigned
    s2_d.rm_v  = 64'($unsigned(s1_q.md[31] ? 32'(-s1_q.md) : 32'(s1_q.md))) << FRAC_BITS;
    s2_d.sx    = s1_q.pmx[63];
    s2_d.sy    = s1_q.pmy[63];
    s2_d.neg_e = s1_q.md[31] ^ s1_q.ep[32];
    s2_d.bigx  = {2'b00, s2_d.rm_x} >= (66'(s1_q.rho) << QM);
    s2_d.bigy  = {2'b00, s2_d.rm_y} >= (66'(s1_q.rho) << QM);
    s2_d.ue    = s1_q.ep[32] ? 33'(-s1_q.ep) : 33'(s1_q.ep);
    s2_d.pr    = s1_q.pr;
    s2_d.dir   = s1_q.dir;
    s2_d.md    = s1_q.md;
    s2_d.rho   = s1_q.rho;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= s2_d;
    end
  end

  // Restoring divider stages, one quotient bit each, MSB first
  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    localparam int B  = NSTEP - 1 - k;
    localparam int BX = (B < QM) ? B : 0;
    logic [DW-1:0] dsh;
    div_t          nx;

    always_comb begin
      nx  = dv_q[k];
      dsh = DW'(dv_q[k].rho) << B;
      if (DW'(dv_q[k].rm_v) >= dsh) begin
        nx.rm_v  = dv_q[k].rm_v - 64'(dsh);
        nx.qv[B] = 1'b1;
      end
      if (B < QM && DW'(dv_q[k].rm_x) >= dsh) begin
        nx.rm_x   = dv_q[k].rm_x - 64'(dsh);
        nx.qx[BX] = 1'b1;
      end
      if (B < QM && DW'(dv_q[k].rm_y) >= dsh) begin
        nx.rm_y   = dv_q[k].rm_y - 64'(dsh);
        nx.qy[BX] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= nx;
      end
    end
  end

  // Signed quotient plus optional pressure, saturated: {sat, value}
  function automatic logic [32:0] mom_fin(input logic [QM-1:0] q, input logic s,
                                          input logic big, input logic signed [31:0] p,
                                          input logic addp);
    logic signed [QM+1:0] qs;
    logic signed [QM+1:0] sum;
    logic                 ovf;
    qs  = s ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum = qs + (addp ? (QM+2)'(p) : '0);
    ovf = !((&sum[QM+1:31]) || !(|sum[QM+1:31]));
    if (big) begin
      mom_fin = {1'b1, s ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else if (ovf) begin
      mom_fin = {1'b1, sum[QM+1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else begin
      mom_fin = {1'b0, sum[31:0]};
    end
  endfunction

  // Post stage 1: momentum fluxes and the energy partial products
  logic [32:0] fx_w;
  logic [32:0] fy_w;
  assign fx_w = mom_fin(dv_q[NSTEP].qx, dv_q[NSTEP].sx, dv_q[NSTEP].bigx,
                        dv_q[NSTEP].pr, !dv_q[NSTEP].dir);
  assign fy_w = mom_fin(dv_q[NSTEP].qy, dv_q[NSTEP].sy, dv_q[NSTEP].bigy,
                        dv_q[NSTEP].pr, dv_q[NSTEP].dir);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.fx    <= fx_w[31:0];
      p1_q.fy    <= fy_w[31:0];
      p1_q.satm  <= fx_w[32] | fy_w[32];
      p1_q.mlo   <= 65'(dv_q[NSTEP].qv[31:0]) * 65'(dv_q[NSTEP].ue);
      p1_q.mhi   <= (HW+33)'(dv_q[NSTEP].qv[NSTEP-1:32]) * (HW+33)'(dv_q[NSTEP].ue);
      p1_q.neg_e <= dv_q[NSTEP].neg_e;
      p1_q.md    <= dv_q[NSTEP].md;
      p1_q.zero  <= (dv_q[NSTEP].rho == '0);
    end
  end

  // Post stage 2: energy flux, status and the output register
  logic [SW-1:0]  esum;
  logic [SW-1:0]  eprod;
  logic           esat;
  ef2d_pkg::out_t res_d;
  always_comb begin
    esum  = (SW'(p1_q.mhi) << 32) + SW'(p1_q.mlo);
    eprod = esum >> FRAC_BITS;
    esat  = eprod > (SW'(32'h7FFF_FFFF) + SW'(p1_q.neg_e));
    res_d.mass_flux  = p1_q.md;
    res_d.mom_x_flux = p1_q.fx;
    res_d.mom_y_flux = p1_q.fy;
    if (esat) begin
      res_d.energy_flux = p1_q.neg_e ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res_d.energy_flux = p1_q.neg_e ? -eprod[31:0] : eprod[31:0];
    end
    res_d.status = (esat | p1_q.satm) ? ef2d_pkg::ST_SAT : ef2d_pkg::ST_OK;
    if (p1_q.zero) begin
      res_d = '0;
      res_d.status = ef2d_pkg::ST_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end

  // Checks
  `EF_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !en,
                  $stable({v1_q, vd_q, vp1_q, out_valid_q}))
  `EF_ASSERT_NOW(a_zero_result, clk_i, rst_ni,
                 out_valid_o && out_data_o.status == ef2d_pkg::ST_ZERO,
                 out_data_o.mass_flux == 0 && out_data_o.energy_flux == 0)

endmodule
